// ----- sv/msqs_pkg.sv -----
`timescale 1ns / 1ps

package msqs_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCOUNT_W    = QADDR_W + 1;
	localparam int TIME_W      = 32;
	localparam int AREA_W      = 64;
	localparam int SRV_W       = 8;
	localparam int INSYS_W     = 10;
	localparam int SERVED_W    = 32;
	localparam int IN_DATA_W   = 64;
	localparam int OUT_DATA_W  = 416;

	typedef enum logic [1:0] {
		FUNC_ARRIVE = 2'd0,
		FUNC_DEPART = 2'd1,
		FUNC_CLOSE  = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	// Elapsed time, clamped at zero when time runs backwards.
	function automatic logic [TIME_W-1:0] tdelta(input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] mark);
		return (now > mark) ? (now - mark) : '0;
	endfunction

	function automatic logic [AREA_W-1:0] sat_add(input logic [AREA_W-1:0] a,
		input logic [AREA_W-1:0] b);
		logic [AREA_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[AREA_W] ? '1 : s[AREA_W-1:0];
	endfunction

endpackage

// ----- sv/multi_server_queue_statistics.sv -----
`timescale 1ns / 1ps
// The event word is accepted into the input register; the state update then loads the
// result register. Throughput: one event per cycle while the result register is empty
// or being read; the state update of one event, with its three settle multiply-adds and
// one FIFO push or pop, is combinational.
// Reset (arst_n low) clears all counters, areas and marks and sets one idle server;
// the arrival FIFO storage is not cleared and needs no clearing pass.
module multi_server_queue_statistics (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [msqs_pkg::SRV_W-1:0]         cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// event_time, carried_wait
	input  logic [msqs_pkg::IN_DATA_W-1:0]     s_tdata,
	// func
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// start_service, wait_time, free_count, queue_count, served_total,
	// longest_queue, queue_area_out, system_area_out, idle_area_out,
	// wait_sum_out, empty_time_out, refused, zero padding
	output logic [msqs_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int TW = msqs_pkg::TIME_W;
	localparam int AW = msqs_pkg::AREA_W;

	// Input register
	logic                     valid_s1;
	msqs_pkg::func_t          func_s1;
	logic [TW-1:0]            time_s1;
	logic [TW-1:0]            carried_s1;

	// State
	logic [msqs_pkg::SRV_W-1:0]    free_q;
	logic [msqs_pkg::QCOUNT_W-1:0] waiting_q;
	logic [msqs_pkg::INSYS_W-1:0]  in_sys_q;
	logic [msqs_pkg::SERVED_W-1:0] served_q;
	logic [msqs_pkg::QCOUNT_W-1:0] peak_q;
	logic [AW-1:0]                 queue_area_q, system_area_q, idle_area_q;
	logic [AW-1:0]                 wait_total_q, empty_total_q;
	logic [TW-1:0]                 empty_since_q, queue_mark_q, idle_mark_q, system_mark_q;
	logic [msqs_pkg::QADDR_W-1:0]  head_q;
	logic [TW-1:0]                 head_data_q;
	logic [TW-1:0]                 arrival_fifo [msqs_pkg::QUEUE_DEPTH];

	// Result register (the remaining result fields are the state registers, which change only
	// when this register reloads, or for free_q also on a register write)
	logic          out_valid_q;
	logic          start_q;
	logic          refused_q;
	logic [TW-1:0] wait_q;

	logic advance;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1    <= msqs_pkg::func_t'(s_tuser);
			time_s1    <= s_tdata[TW-1:0];
			carried_s1 <= s_tdata[2*TW-1:TW];
		end
	end

	// Settle terms; counts are narrow so products cannot overflow the area width
	logic [AW-1:0] q_add, sys_add, idle_add;
	logic [AW-1:0] q_settled, sys_settled, idle_settled;
	logic [AW-1:0] empty_settled;
	assign q_add    = AW'(msqs_pkg::tdelta(time_s1, queue_mark_q) * waiting_q);
	assign sys_add  = AW'(msqs_pkg::tdelta(time_s1, system_mark_q) * in_sys_q);
	assign idle_add = AW'(msqs_pkg::tdelta(time_s1, idle_mark_q) * free_q);
	assign q_settled    = msqs_pkg::sat_add(queue_area_q, q_add);
	assign sys_settled  = msqs_pkg::sat_add(system_area_q, sys_add);
	assign idle_settled = msqs_pkg::sat_add(idle_area_q, idle_add);
	assign empty_settled = msqs_pkg::sat_add(empty_total_q,
		AW'(msqs_pkg::tdelta(time_s1, empty_since_q)));

	logic                       settle_q, settle_sys, settle_idle;
	logic                       push, pop, start_d, refused_d;
	logic [TW-1:0]              wait_d;
	logic [msqs_pkg::SRV_W-1:0]    free_d;
	logic [msqs_pkg::QCOUNT_W-1:0] waiting_d, peak_d;
	logic [msqs_pkg::INSYS_W-1:0]  in_sys_d;
	logic [msqs_pkg::SERVED_W-1:0] served_d;
	logic [AW-1:0]                 wait_total_d, empty_total_d;
	logic [TW-1:0]                 empty_since_d;

	always_comb begin
		settle_q      = 1'b0;
		settle_sys    = 1'b0;
		settle_idle   = 1'b0;
		push          = 1'b0;
		pop           = 1'b0;
		start_d       = 1'b0;
		refused_d     = 1'b0;
		wait_d        = '0;
		free_d        = free_q;
		waiting_d     = waiting_q;
		peak_d        = peak_q;
		in_sys_d      = in_sys_q;
		served_d      = served_q;
		wait_total_d  = wait_total_q;
		empty_total_d = empty_total_q;
		empty_since_d = empty_since_q;
		case (func_s1)
			msqs_pkg::FUNC_ARRIVE: begin
				if (free_q == '0 && waiting_q >= msqs_pkg::QCOUNT_W'(msqs_pkg::QUEUE_DEPTH)) begin
					refused_d = 1'b1;
				end else begin
					settle_sys = 1'b1;
					in_sys_d   = in_sys_q + 1'b1;
					if (free_q != '0) begin
						settle_idle = 1'b1;
						free_d      = free_q - 1'b1;
						start_d     = 1'b1;
					end else begin
						if (waiting_q == '0) begin
							empty_total_d = empty_settled;
						end
						settle_q  = 1'b1;
						push      = 1'b1;
						waiting_d = waiting_q + 1'b1;
						if (waiting_d > peak_q) begin
							peak_d = waiting_d;
						end
					end
				end
			end
			msqs_pkg::FUNC_DEPART: begin
				if (in_sys_q != '0) begin
					settle_sys   = 1'b1;
					in_sys_d     = in_sys_q - 1'b1;
					served_d     = (served_q != '1) ? served_q + 1'b1 : served_q;
					wait_total_d = msqs_pkg::sat_add(wait_total_q, AW'(carried_s1));
					if (waiting_q != '0) begin
						settle_q  = 1'b1;
						pop       = 1'b1;
						waiting_d = waiting_q - 1'b1;
						if (waiting_d == '0) begin
							empty_since_d = time_s1;
						end
						wait_d  = msqs_pkg::tdelta(time_s1, head_data_q);
						start_d = 1'b1;
					end else begin
						settle_idle = 1'b1;
						if (free_q != '1) begin
							free_d = free_q + 1'b1;
						end
					end
				end
			end
			msqs_pkg::FUNC_CLOSE: begin
				settle_q    = 1'b1;
				settle_sys  = 1'b1;
				settle_idle = 1'b1;
				if (waiting_q == '0) begin
					empty_total_d = empty_settled;
					empty_since_d = time_s1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q        <= msqs_pkg::SRV_W'(1);
			waiting_q     <= '0;
			in_sys_q      <= '0;
			served_q      <= '0;
			peak_q        <= '0;
			queue_area_q  <= '0;
			system_area_q <= '0;
			idle_area_q   <= '0;
			wait_total_q  <= '0;
			empty_total_q <= '0;
			empty_since_q <= '0;
			queue_mark_q  <= '0;
			idle_mark_q   <= '0;
			system_mark_q <= '0;
			head_q        <= '0;
			out_valid_q   <= 1'b0;
			start_q       <= 1'b0;
			refused_q     <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q   <= 1'b1;
				start_q       <= start_d;
				refused_q     <= refused_d;
				waiting_q     <= waiting_d;
				in_sys_q      <= in_sys_d;
				served_q      <= served_d;
				peak_q        <= peak_d;
				wait_total_q  <= wait_total_d;
				empty_total_q <= empty_total_d;
				empty_since_q <= empty_since_d;
				if (settle_q) begin
					queue_area_q <= q_settled;
					queue_mark_q <= time_s1;
				end
				if (settle_sys) begin
					system_area_q <= sys_settled;
					system_mark_q <= time_s1;
				end
				if (settle_idle) begin
					idle_area_q <= idle_settled;
					idle_mark_q <= time_s1;
				end
				if (pop) begin
					head_q <= head_q + 1'b1;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			// A register write reloads the idle servers; the user must write only while the block is idle, unenforced.
			if (cfg_valid && cfg_ready) begin
				free_q <= cfg_data;
			end else if (advance) begin
				free_q <= free_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wait_q <= wait_d;
		end
	end

	// Arrival FIFO: one write and one read a cycle. The word at the head is kept in
	// head_data_q, with the new arrival forwarded when it lands at the head.
	logic                         wr_en;
	logic [msqs_pkg::QADDR_W-1:0] wr_addr, head_next;
	assign wr_en     = advance && push;
	assign wr_addr   = head_q + waiting_q[msqs_pkg::QADDR_W-1:0];
	assign head_next = (advance && pop) ? head_q + 1'b1 : head_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			arrival_fifo[wr_addr] <= time_s1;
		end
		if (wr_en && wr_addr == head_next) begin
			head_data_q <= time_s1;
		end else begin
			head_data_q <= arrival_fifo[head_next];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, refused_q, empty_total_q, wait_total_q, idle_area_q,
		system_area_q, queue_area_q, peak_q, served_q, waiting_q, free_q, wait_q, start_q};

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		waiting_q <= msqs_pkg::QCOUNT_W'(msqs_pkg::QUEUE_DEPTH))
		else $error("queue count beyond FIFO depth");

	a_peak_covers: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= waiting_q)
		else $error("peak queue length below current queue length");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pop) |=> (waiting_q == $past(waiting_q) - 1'b1))
		else $error("queue count did not fall after a pop");

	a_refuse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && refused_q) |-> (!start_q && wait_q == '0))
		else $error("refused arrival reported a service start");

endmodule

// ----- verif/multi_server_queue_statistics_tb.sv -----
`timescale 1ns / 1ps

module multi_server_queue_statistics_tb;
	import msqs_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT    = 2000;
	localparam int unsigned PHASES            = 8;
	localparam int unsigned PHASE_ITEMS       = 200;
	localparam int unsigned FLOOD_PHASE       = 2;
	localparam int unsigned FLOOD_ITEMS       = 270;
	localparam int unsigned PAUSE_PHASE       = 5;
	localparam int unsigned RANDOM_SIZE_PHASE = 4;
	localparam int unsigned SEND_IDLE [4]     = '{0, 68, 0, 20};
	localparam int unsigned RECV_STALL [4]    = '{0, 0, 68, 20};
	localparam int unsigned PHASE_SERVERS [8] = '{1, 255, 1, 4, 128, 2, 1, 255};

	// One result word; the first field sits in the lowest bits, hence the reversed order.
	typedef struct packed {
		logic [OUT_DATA_W-413:0] pad;
		logic                    refused;
		logic [AREA_W-1:0]       empty_time_out;
		logic [AREA_W-1:0]       wait_sum_out;
		logic [AREA_W-1:0]       idle_area_out;
		logic [AREA_W-1:0]       system_area_out;
		logic [AREA_W-1:0]       queue_area_out;
		logic [QCOUNT_W-1:0]     longest_queue;
		logic [SERVED_W-1:0]     served_total;
		logic [QCOUNT_W-1:0]     queue_count;
		logic [SRV_W-1:0]        free_count;
		logic [TIME_W-1:0]       wait_time;
		logic                    start_service;
	} result_t;

	typedef enum bit {ROW_EVENT, ROW_CONFIG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		func_t             func;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] carried;
		logic [SRV_W-1:0]  servers;
		bit                typed_in;
		result_t           want;
	} stim_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [SRV_W-1:0]      cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [1:0]            s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Model of the queue book-keeping, at the block's widths.
	logic [SRV_W-1:0]    idle_servers = 8'd1;
	logic [QCOUNT_W-1:0] queued       = '0;
	logic [INSYS_W-1:0]  in_sys       = '0;
	logic [SERVED_W-1:0] departures   = '0;
	logic [QCOUNT_W-1:0] queue_peak   = '0;
	logic [AREA_W-1:0]   q_area       = '0;
	logic [AREA_W-1:0]   s_area       = '0;
	logic [AREA_W-1:0]   i_area       = '0;
	logic [AREA_W-1:0]   waits_sum    = '0;
	logic [AREA_W-1:0]   empty_sum    = '0;
	logic [TIME_W-1:0]   empty_from   = '0;
	logic [TIME_W-1:0]   q_mark       = '0;
	logic [TIME_W-1:0]   s_mark       = '0;
	logic [TIME_W-1:0]   i_mark       = '0;
	logic [TIME_W-1:0]   arrival_times [$];

	result_t           expected_stats [$];
	stim_row_t         table_rows [$];
	result_t           got_word;
	result_t           want_word;
	logic [TIME_W-1:0] clock_now;
	int unsigned       send_idle_pct  = 0;
	int unsigned       recv_stall_pct = 0;
	int unsigned       mismatch_count = 0;
	int unsigned       events_sent    = 0;
	int unsigned       words_checked  = 0;
	int unsigned       refusals       = 0;
	int unsigned       settings_made  = 0;
	int unsigned       quiet_cycles   = 0;

	multi_server_queue_statistics DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] since);
		return (now > since) ? now - since : '0;
	endfunction

	function automatic logic [AREA_W-1:0] add_clip(input logic [AREA_W-1:0] a,
		input logic [AREA_W-1:0] b);
		logic [AREA_W:0] total;
		total = {1'b0, a} + {1'b0, b};
		return total[AREA_W] ? '1 : total[AREA_W-1:0];
	endfunction

	// Adds the area under a constant count since the mark, then moves the mark.
	task automatic accrue(inout logic [AREA_W-1:0] area, inout logic [TIME_W-1:0] mark,
		input logic [TIME_W-1:0] now, input int unsigned count);
		area = add_clip(area, AREA_W'(elapsed(now, mark)) * count);
		mark = now;
	endtask

	task automatic advance_queue_model(input func_t f, input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] carried, output result_t r);
		r = '0;
		case (f)
			FUNC_ARRIVE: begin
				if (idle_servers == 0 && queued >= QUEUE_DEPTH) begin
					r.refused = 1'b1;
				end else begin
					accrue(s_area, s_mark, now, 32'(in_sys));
					in_sys++;
					if (idle_servers > 0) begin
						accrue(i_area, i_mark, now, 32'(idle_servers));
						idle_servers--;
						r.start_service = 1'b1;
					end else begin
						if (queued == 0)
							empty_sum = add_clip(empty_sum, AREA_W'(elapsed(now, empty_from)));
						accrue(q_area, q_mark, now, 32'(queued));
						arrival_times.insert(arrival_times.size(), now);
						queued++;
						if (queued > queue_peak)
							queue_peak = queued;
					end
				end
			end
			FUNC_DEPART: begin
				if (in_sys != 0) begin
					accrue(s_area, s_mark, now, 32'(in_sys));
					in_sys--;
					if (departures != '1)
						departures++;
					waits_sum = add_clip(waits_sum, AREA_W'(carried));
					if (queued > 0) begin
						accrue(q_area, q_mark, now, 32'(queued));
						queued--;
						if (queued == 0)
							empty_from = now;
						r.wait_time = elapsed(now, arrival_times[0]);
						arrival_times.delete(0);
						r.start_service = 1'b1;
					end else begin
						accrue(i_area, i_mark, now, 32'(idle_servers));
						if (idle_servers != 8'hFF)
							idle_servers++;
					end
				end
			end
			FUNC_CLOSE: begin
				accrue(q_area, q_mark, now, 32'(queued));
				accrue(s_area, s_mark, now, 32'(in_sys));
				if (queued == 0) begin
					empty_sum = add_clip(empty_sum, AREA_W'(elapsed(now, empty_from)));
					empty_from = now;
				end
				accrue(i_area, i_mark, now, 32'(idle_servers));
			end
			default: begin
			end
		endcase
		r.free_count      = idle_servers;
		r.queue_count     = queued;
		r.served_total    = departures;
		r.longest_queue   = queue_peak;
		r.queue_area_out  = q_area;
		r.system_area_out = s_area;
		r.idle_area_out   = i_area;
		r.wait_sum_out    = waits_sum;
		r.empty_time_out  = empty_sum;
	endtask

	task automatic send_event(input func_t f, input logic [TIME_W-1:0] stamp,
		input logic [TIME_W-1:0] carried, input bit typed_in, input result_t fixed);
		result_t forecast;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {carried, stamp};
		do @(posedge clk); while (!s_tready);
		advance_queue_model(f, stamp, carried, forecast);
		expected_stats.insert(expected_stats.size(), typed_in ? fixed : forecast);
		events_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_stats.size() != 0);
	endtask

	task automatic write_servers(input logic [SRV_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		idle_servers = value;
		settings_made++;
	endtask

	function automatic void check_field(input string name, input logic [AREA_W-1:0] want,
		input logic [AREA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (m_tvalid && m_tready) begin
			got_word = m_tdata;
			if (expected_stats.size() == 0) begin
				$error("Result word arrived with no event outstanding");
				mismatch_count++;
			end else begin
				want_word = expected_stats[0];
				expected_stats.delete(0);
				check_field("start_service", AREA_W'(want_word.start_service),
					AREA_W'(got_word.start_service));
				check_field("wait_time", AREA_W'(want_word.wait_time),
					AREA_W'(got_word.wait_time));
				check_field("free_count", AREA_W'(want_word.free_count),
					AREA_W'(got_word.free_count));
				check_field("queue_count", AREA_W'(want_word.queue_count),
					AREA_W'(got_word.queue_count));
				check_field("served_total", AREA_W'(want_word.served_total),
					AREA_W'(got_word.served_total));
				check_field("longest_queue", AREA_W'(want_word.longest_queue),
					AREA_W'(got_word.longest_queue));
				check_field("queue_area_out", want_word.queue_area_out,
					got_word.queue_area_out);
				check_field("system_area_out", want_word.system_area_out,
					got_word.system_area_out);
				check_field("idle_area_out", want_word.idle_area_out, got_word.idle_area_out);
				check_field("wait_sum_out", want_word.wait_sum_out, got_word.wait_sum_out);
				check_field("empty_time_out", want_word.empty_time_out,
					got_word.empty_time_out);
				check_field("refused", AREA_W'(want_word.refused), AREA_W'(got_word.refused));
			end
			if (got_word.refused === 1'b1)
				refusals++;
			words_checked++;
		end
	end

	// Any word moving on any channel counts as progress.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("No word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		result_t           w;
		int unsigned       servers;
		int unsigned       pick;
		int unsigned       depart_pct;
		func_t             f;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] carried;

		// Straight after reset the state can be read off directly.
		w = '0;
		w.free_count = 8'd1;
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_NOP, 32'd0, 32'd0, 8'd0, 1'b1, w});
		// A departure from an empty system is ignored, even with the largest wait.
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_DEPART, 32'd50, 32'hFFFF_FFFF, 8'd0, 1'b1, w});
		w.start_service = 1'b1;
		w.free_count    = 8'd0;
		w.idle_area_out = 64'd100;
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_ARRIVE, 32'd100, 32'd0, 8'd0, 1'b1, w});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_ARRIVE, 32'd300, 32'd0, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_ARRIVE, 32'd350, 32'd0, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_DEPART, 32'd1000, 32'd0, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_CLOSE, 32'd1200, 32'd0, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_CLOSE, 32'd1200, 32'd0, 8'd0, 1'b0, '0});
		// Time running backwards.
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_ARRIVE, 32'd900, 32'd0, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_DEPART, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_DEPART, 32'd5, 32'd7, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_DEPART, 32'd10, 32'd1, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_CLOSE, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_NOP, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_CONFIG, FUNC_NOP, 32'd0, 32'd0, 8'd255, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_ARRIVE, 32'd2000, 32'd0, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_ARRIVE, 32'd2100, 32'd0, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_ARRIVE, 32'd2200, 32'd0, 8'd0, 1'b0, '0});
		// Reloading the idle count with customers still in service, so that the
		// next departures must hold it at its ceiling.
		table_rows.insert(table_rows.size(),
			'{ROW_CONFIG, FUNC_NOP, 32'd0, 32'd0, 8'd255, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_DEPART, 32'd3000, 32'd40, 8'd0, 1'b0, '0});
		table_rows.insert(table_rows.size(),
			'{ROW_EVENT, FUNC_DEPART, 32'd3500, 32'd0, 8'd0, 1'b0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) begin
			if (table_rows[i].kind == ROW_CONFIG)
				write_servers(table_rows[i].servers);
			else
				send_event(table_rows[i].func, table_rows[i].stamp, table_rows[i].carried,
					table_rows[i].typed_in, table_rows[i].want);
		end

		clock_now = $urandom_range(1000);
		for (int p = 0; p < PHASES; p++) begin
			servers = (p == RANDOM_SIZE_PHASE) ? $urandom_range(254, 2) : PHASE_SERVERS[p];
			write_servers(servers[SRV_W-1:0]);
			send_idle_pct  = SEND_IDLE[p % 4];
			recv_stall_pct = RECV_STALL[p % 4];
			for (int i = 0; i < PHASE_ITEMS + ((p == FLOOD_PHASE) ? FLOOD_ITEMS : 0); i++) begin
				clock_now += $urandom_range(3000);
				stamp   = ($urandom_range(99) < 6) ? $urandom() : clock_now;
				carried = ($urandom_range(99) < 8) ? $urandom() : $urandom_range(20000);
				// Lean towards departures once the system fills, so queues rise and fall.
				depart_pct = (in_sys > 24) ? 65 : 42;
				pick = $urandom_range(99);
				if (p == FLOOD_PHASE && i < FLOOD_ITEMS)
					f = FUNC_ARRIVE;
				else if (pick < 3)
					f = FUNC_NOP;
				else if (pick < 10)
					f = FUNC_CLOSE;
				else if (pick < 10 + depart_pct)
					f = FUNC_DEPART;
				else
					f = FUNC_ARRIVE;
				if (p == PAUSE_PHASE && i == PHASE_ITEMS / 2)
					wait_drained();
				send_event(f, stamp, carried, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Covered %0d events and %0d result words over %0d server-count settings,",
			events_sent, words_checked, settings_made);
		$display("with %0d arrivals refused at a full queue and a longest queue of %0d.",
			refusals, queue_peak);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/msqs_pkg.sv
sv/multi_server_queue_statistics.sv
verif/multi_server_queue_statistics_tb.sv
